// ===== sv/hbwd_pkg.sv =====
// hbwd_pkg: shared types and constants of the heartbeat watchdog
// covers the event encoding, register map, reset values and the structs passed between modules
// no dependencies

package hbwd_pkg;

    localparam int TS_W    = 32;
    localparam int CH_W    = 3;
    localparam int CAUSE_W = 3;
    localparam int SEC_W   = 16;
    localparam int APB_AW  = 4;
    localparam int APB_DW  = 32;

    // event codes carried in tuser
    typedef enum logic [1:0] {
        FUNC_START      = 2'd0,
        FUNC_FEED       = 2'd1,
        FUNC_MARK       = 2'd2,
        FUNC_SET_ACTIVE = 2'd3
    } t_func;

    // register index, byte address / 4
    typedef enum logic [1:0] {
        REG_SW_SEC   = 2'd0,
        REG_MODEM_MS = 2'd1,
        REG_COMM_MS  = 2'd2,
        REG_OTA_MS   = 2'd3
    } t_reg;

    localparam logic [CAUSE_W-1:0] CAUSE_NONE    = 3'd0;
    localparam logic [CAUSE_W-1:0] CAUSE_FEED    = 3'd1;
    localparam logic [CAUSE_W-1:0] CAUSE_CH_BASE = 3'd2;

    // channels with special handling
    localparam int CH_MODEM = 0;
    localparam int CH_MQTT  = 2;
    localparam int CH_OTA   = 4;

    localparam logic [SEC_W-1:0] MIN_SW_SEC    = 16'd30;
    localparam logic [TS_W-1:0]  MS_PER_SEC    = 32'd1000;
    localparam logic [SEC_W-1:0] RST_SW_SEC    = 16'd30;
    localparam logic [TS_W-1:0]  RST_SW_MS     = 32'd30000;
    localparam logic [TS_W-1:0]  RST_MODEM_MS  = 32'd900000;
    localparam logic [TS_W-1:0]  RST_COMM_MS   = 32'd600000;
    localparam logic [TS_W-1:0]  RST_OTA_MS    = 32'd60000;

    typedef struct packed {
        t_func             func;
        logic [CH_W-1:0]   channel;
        logic              active_flag;
        logic [TS_W-1:0]   now_ms;
    } t_item;

    typedef struct packed {
        logic               restart;
        logic [CAUSE_W-1:0] cause;
    } t_result;

    // limits as seen by the checking logic, feed limit already in ms
    typedef struct packed {
        logic [TS_W-1:0] sw_limit_ms;
        logic [TS_W-1:0] modem_ms;
        logic [TS_W-1:0] comm_ms;
        logic [TS_W-1:0] ota_ms;
    } t_limits;

endpackage

// ===== sv/hbwd_cfg.sv =====
// hbwd_cfg: apb register bank holding the timeout settings
// depends on hbwd_pkg; the feed limit is converted to ms when written

module hbwd_cfg
    import hbwd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_limits           o_limits
);

    logic [SEC_W-1:0] r_sw_sec, n_sw_sec;
    logic [TS_W-1:0]  r_sw_ms, n_sw_ms;
    logic [TS_W-1:0]  r_modem_ms, n_modem_ms;
    logic [TS_W-1:0]  r_comm_ms, n_comm_ms;
    logic [TS_W-1:0]  r_ota_ms, n_ota_ms;
    logic [SEC_W-1:0] w_sec_clamped;
    logic             w_wr;
    t_reg             w_reg;

    assign pready        = 1'b1;
    assign w_wr          = psel & penable & pwrite;
    assign w_reg         = t_reg'(paddr[3:2]);
    assign w_sec_clamped = (pwdata[SEC_W-1:0] < MIN_SW_SEC) ? MIN_SW_SEC : pwdata[SEC_W-1:0];

    always_comb begin
        n_sw_sec   = r_sw_sec;
        n_sw_ms    = r_sw_ms;
        n_modem_ms = r_modem_ms;
        n_comm_ms  = r_comm_ms;
        n_ota_ms   = r_ota_ms;
        if (w_wr) begin
            unique case (w_reg)
                REG_SW_SEC: begin
                    n_sw_sec = w_sec_clamped;
                    n_sw_ms  = TS_W'({16'd0, w_sec_clamped} * MS_PER_SEC);
                end
                REG_MODEM_MS: n_modem_ms = pwdata;
                REG_COMM_MS:  n_comm_ms  = pwdata;
                REG_OTA_MS:   n_ota_ms   = pwdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw_sec   <= RST_SW_SEC;
            r_sw_ms    <= RST_SW_MS;
            r_modem_ms <= RST_MODEM_MS;
            r_comm_ms  <= RST_COMM_MS;
            r_ota_ms   <= RST_OTA_MS;
        end else begin
            r_sw_sec   <= n_sw_sec;
            r_sw_ms    <= n_sw_ms;
            r_modem_ms <= n_modem_ms;
            r_comm_ms  <= n_comm_ms;
            r_ota_ms   <= n_ota_ms;
        end
    end

    always_comb begin
        unique case (w_reg)
            REG_SW_SEC:   prdata = {16'd0, r_sw_sec};
            REG_MODEM_MS: prdata = r_modem_ms;
            REG_COMM_MS:  prdata = r_comm_ms;
            REG_OTA_MS:   prdata = r_ota_ms;
            default:      prdata = '0;
        endcase
    end

    assign o_limits.sw_limit_ms = r_sw_ms;
    assign o_limits.modem_ms    = r_modem_ms;
    assign o_limits.comm_ms     = r_comm_ms;
    assign o_limits.ota_ms      = r_ota_ms;

endmodule

// ===== sv/hbwd_core.sv =====
// hbwd_core: watchdog state and the combinational event evaluation
// depends on hbwd_pkg; state advances only when the caller fires an event

module hbwd_core
    import hbwd_pkg::*;
#(
    parameter int CHANNELS = 5
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    input  t_limits i_limits,
    output t_result o_result
);

    logic                r_running, n_running;
    logic [TS_W-1:0]     r_last_feed, n_last_feed;
    logic [TS_W-1:0]     r_seen [CHANNELS];
    logic [TS_W-1:0]     n_seen [CHANNELS];
    logic [CHANNELS-1:0] r_active, n_active;

    logic [TS_W-1:0]     w_feed_age;
    logic                w_feed_to;
    logic [TS_W-1:0]     w_age [CHANNELS];
    logic [TS_W-1:0]     w_lim [CHANNELS];
    logic [CHANNELS-1:0] w_exp;
    logic [CHANNELS-1:0] w_sel;
    logic [CAUSE_W-1:0]  w_ch_cause;
    logic [CAUSE_W-1:0]  w_cause;

    assign w_feed_age = i_item.now_ms - r_last_feed;
    assign w_feed_to  = (r_last_feed != '0) && (w_feed_age > i_limits.sw_limit_ms);

    // per-channel age checks, all in parallel
    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            if (c == CH_MODEM)    w_lim[c] = i_limits.modem_ms;
            else if (c == CH_OTA) w_lim[c] = i_limits.ota_ms;
            else                  w_lim[c] = i_limits.comm_ms;
            w_age[c] = i_item.now_ms - r_seen[c];
            w_exp[c] = r_active[c] && (r_seen[c] != '0) && (w_age[c] > w_lim[c]);
            w_sel[c] = ({2'b00, i_item.channel} == 5'(c));
        end
    end

    // lowest expired channel wins
    always_comb begin
        w_ch_cause = CAUSE_NONE;
        for (int c = CHANNELS - 1; c >= 0; c--) begin
            if (w_exp[c]) w_ch_cause = CAUSE_W'(CAUSE_CH_BASE + c);
        end
    end

    always_comb begin
        n_running   = r_running;
        n_last_feed = r_last_feed;
        n_active    = r_active;
        w_cause     = CAUSE_NONE;
        for (int c = 0; c < CHANNELS; c++) n_seen[c] = r_seen[c];
        case (i_item.func)
            FUNC_START: begin
                n_running   = 1'b1;
                n_last_feed = i_item.now_ms;
            end
            FUNC_FEED: begin
                if (r_running) begin
                    if (w_feed_to) begin
                        w_cause = CAUSE_FEED;
                    end else begin
                        n_last_feed = i_item.now_ms;
                        w_cause     = w_ch_cause;
                    end
                end
            end
            FUNC_MARK: begin
                for (int c = 0; c < CHANNELS; c++) begin
                    if (w_sel[c]) begin
                        n_seen[c]   = i_item.now_ms;
                        n_active[c] = 1'b1;
                    end
                end
            end
            FUNC_SET_ACTIVE: begin
                for (int c = 0; c < CHANNELS; c++) begin
                    if (w_sel[c] && c == CH_MQTT) begin
                        n_active[c] = i_item.active_flag;
                        if (i_item.active_flag && r_seen[c] == '0) n_seen[c] = i_item.now_ms;
                    end else if (w_sel[c] && c == CH_OTA) begin
                        n_active[c] = i_item.active_flag;
                        if (i_item.active_flag) n_seen[c] = i_item.now_ms;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running   <= 1'b0;
            r_last_feed <= '0;
            r_active    <= '0;
            for (int c = 0; c < CHANNELS; c++) r_seen[c] <= '0;
        end else if (i_fire) begin
            r_running   <= n_running;
            r_last_feed <= n_last_feed;
            r_active    <= n_active;
            for (int c = 0; c < CHANNELS; c++) r_seen[c] <= n_seen[c];
        end
    end

    assign o_result.restart = (w_cause != CAUSE_NONE);
    assign o_result.cause   = w_cause;

endmodule

// ===== sv/multi_channel_heartbeat_watchdog_top.sv =====
// multi_channel_heartbeat_watchdog_top: top level of the heartbeat watchdog
// depends on hbwd_pkg, hbwd_cfg and hbwd_core
//
//  channel   | direction | handshake              | contents
//  ----------+-----------+------------------------+------------------------------------
//  event in  | slave     | i_s_tvalid/o_s_tready  | tuser: func, channel; tdata: flag, now
//  result    | master    | o_m_tvalid/i_m_tready  | tdata: restart, cause
//  config    | apb       | psel/penable/pready    | four timeout registers, 4-byte stride
//
// one event per clock while the result side does not stall; each event waits in the
// input register, where the state is read and updated, and then sits in the result
// register; the result is valid once the event has reached the result register
// the result register decouples the sides: a new event is taken while a result waits,
// and the input register only holds when the result register is full and stalled
// reset (synchronous, active low) clears the state, limits go to their defaults

module multi_channel_heartbeat_watchdog_top
    import hbwd_pkg::*;
#(
    parameter int CHANNELS = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // event stream
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [39:0]       i_s_tdata,   // [0] active_flag, [32:1] now_ms, rest zero
    input  logic [4:0]        i_s_tuser,   // [1:0] func, [4:2] channel
    // result stream
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [7:0]        o_m_tdata,   // [0] restart, [3:1] cause, rest zero
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    t_limits w_limits;
    t_item   w_item_in;
    t_result w_result;

    logic    r_in_valid, n_in_valid;
    t_item   r_in;
    logic    r_out_valid, n_out_valid;
    t_result r_out;

    logic    w_fire;
    logic    w_accept;

    hbwd_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_limits (w_limits)
    );

    hbwd_core #(
        .CHANNELS (CHANNELS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_item   (r_in),
        .i_limits (w_limits),
        .o_result (w_result)
    );

    // unpack the incoming transaction
    assign w_item_in.func        = t_func'(i_s_tuser[1:0]);
    assign w_item_in.channel     = i_s_tuser[4:2];
    assign w_item_in.active_flag = i_s_tdata[0];
    assign w_item_in.now_ms      = i_s_tdata[32:1];

    // the held event is evaluated once the result register can take its answer
    assign w_fire     = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_fire;
    assign w_accept   = i_s_tvalid && o_s_tready;

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_accept)    n_in_valid = 1'b1;
        else if (w_fire) n_in_valid = 1'b0;

        n_out_valid = r_out_valid;
        if (w_fire)          n_out_valid = 1'b1;
        else if (i_m_tready) n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_accept) r_in  <= w_item_in;
        if (w_fire)   r_out <= w_result;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0000, r_out.cause, r_out.restart};

endmodule
